// ----- sv/fpw_pkg.sv -----
// Shared types for the framebuffer pixel writer.
package fpw_pkg;

  typedef enum logic [2:0] {
    REG_BASE_ADDRESS = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_LINE_PITCH   = 3'd3,
    REG_PIXEL_BYTES  = 3'd4,
    REG_RED_LAYOUT   = 3'd5,
    REG_GREEN_LAYOUT = 3'd6,
    REG_BLUE_LAYOUT  = 3'd7
  } reg_index_t;

  localparam int unsigned FIELD_ADDR_W = 48;

  typedef struct packed {
    logic [47:0] base_address;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [15:0] line_pitch;
    logic [2:0]  pixel_bytes;
    logic [8:0]  red_layout;
    logic [8:0]  green_layout;
    logic [8:0]  blue_layout;
  } cfg_t;

  // First stage result: products and offsets.
  typedef struct packed {
    logic [28:0] row_offset;
    logic [14:0] col_offset;
    logic        four_bytes;
    logic [15:0] red_prod;
    logic [15:0] green_prod;
    logic [15:0] blue_prod;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } front_t;

  // Second stage result: a packed pixel ready for byte output.
  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] word;
    logic        four_bytes;
  } pix_t;

endpackage

// ----- sv/fpw_front.sv -----
// Stage one: frame check, row and column offsets, channel scale products.
module fpw_front import fpw_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_pixel_x,
  input  logic [12:0] in_pixel_y,
  input  logic [7:0]  in_red_level,
  input  logic [7:0]  in_green_level,
  input  logic [7:0]  in_blue_level,
  output logic        s1_valid,
  input  logic        s1_ready,
  output front_t      s1_data
);

  localparam logic [16:0] MAX_DIM = 17'(MAX_DIMENSION);

  logic        valid_r, valid_nxt;
  front_t      data_r, data_nxt;
  logic [16:0] w_lim, h_lim;
  logic        in_frame;
  logic [3:0]  r_size, g_size, b_size;

  function automatic logic [7:0] top_of(input logic [3:0] size);
    logic [8:0] t;
    t = (9'd1 << size) - 9'd1;
    if (size == 4'd0 || size > 4'd8) begin
      return 8'd0;
    end
    return t[7:0];
  endfunction

  assign in_ready = !valid_r || s1_ready;
  assign s1_valid = valid_r;
  assign s1_data  = data_r;

  always_comb begin
    w_lim = ({3'b0, cfg.frame_width} > MAX_DIM) ? MAX_DIM : {3'b0, cfg.frame_width};
    h_lim = ({3'b0, cfg.frame_height} > MAX_DIM) ? MAX_DIM : {3'b0, cfg.frame_height};
    in_frame = ({4'b0, in_pixel_x} < w_lim) && ({4'b0, in_pixel_y} < h_lim);
    r_size = cfg.red_layout[8:5];
    g_size = cfg.green_layout[8:5];
    b_size = cfg.blue_layout[8:5];

    data_nxt = data_r;
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid && in_frame;
      data_nxt.four_bytes  = (cfg.pixel_bytes >= 3'd4);
      data_nxt.row_offset  = 29'({16'b0, in_pixel_y} * {13'b0, cfg.line_pitch});
      data_nxt.col_offset  = data_nxt.four_bytes ? {in_pixel_x, 2'b00}
                                                 : ({1'b0, in_pixel_x, 1'b0} +
                                                    {2'b0, in_pixel_x});
      data_nxt.red_prod    = 16'({8'b0, in_red_level} * {8'b0, top_of(r_size)});
      data_nxt.green_prod  = 16'({8'b0, in_green_level} * {8'b0, top_of(g_size)});
      data_nxt.blue_prod   = 16'({8'b0, in_blue_level} * {8'b0, top_of(b_size)});
      data_nxt.red_shift   = cfg.red_layout[4:0];
      data_nxt.green_shift = cfg.green_layout[4:0];
      data_nxt.blue_shift  = cfg.blue_layout[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

// ----- sv/fpw_pack.sv -----
// Stage two: byte address sum and rounded channel packing.
module fpw_pack import fpw_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   s1_valid,
  output logic   s1_ready,
  input  front_t s1_data,
  output logic   s2_valid,
  input  logic   s2_ready,
  output pix_t   s2_data
);

  localparam int unsigned AW_EFF = (ADDRESS_BITS < FIELD_ADDR_W) ? ADDRESS_BITS
                                                                 : FIELD_ADDR_W;
  localparam logic [47:0] ADDR_MASK = {48{1'b1}} >> (FIELD_ADDR_W - AW_EFF);

  logic        valid_r, valid_nxt;
  pix_t        data_r, data_nxt;
  logic [48:0] sum;

  // Rounded divide by 255: for v below 65535, v/255 = (v + (v >> 8) + 1) >> 8.
  function automatic logic [31:0] place(input logic [15:0] prod,
                                        input logic [4:0] shift);
    logic [16:0] v;
    logic [16:0] q;
    v = {1'b0, prod} + 17'd127;
    q = (v + (v >> 8) + 17'd1) >> 8;
    return {24'b0, q[7:0]} << shift;
  endfunction

  assign s1_ready = !valid_r || s2_ready;
  assign s2_valid = valid_r;
  assign s2_data  = data_r;

  always_comb begin
    sum = {1'b0, cfg.base_address} + {20'b0, s1_data.row_offset} +
          {34'b0, s1_data.col_offset};
    data_nxt = data_r;
    valid_nxt = valid_r;
    if (s1_ready) begin
      valid_nxt = s1_valid;
      data_nxt.addr = sum[47:0] & ADDR_MASK;
      data_nxt.word = place(s1_data.red_prod, s1_data.red_shift) |
                      place(s1_data.green_prod, s1_data.green_shift) |
                      place(s1_data.blue_prod, s1_data.blue_shift);
      data_nxt.four_bytes = s1_data.four_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

// ----- sv/fpw_ser.sv -----
// Stage three: splits a packed pixel into byte writes, low byte first.
module fpw_ser import fpw_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s2_valid,
  output logic        s2_ready,
  input  pix_t        s2_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_byte_address,
  output logic [7:0]  out_byte_value,
  output logic        out_last_byte
);

  localparam int unsigned AW_EFF = (ADDRESS_BITS < FIELD_ADDR_W) ? ADDRESS_BITS
                                                                 : FIELD_ADDR_W;
  localparam logic [47:0] ADDR_MASK = {48{1'b1}} >> (FIELD_ADDR_W - AW_EFF);

  logic        valid_r, valid_nxt;
  logic [47:0] addr_r, addr_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        four_r, four_nxt;
  logic        last;

  assign last     = (cnt_r == (four_r ? 2'd3 : 2'd2));
  assign s2_ready = !valid_r || (out_ready && last);

  assign out_valid        = valid_r;
  assign out_byte_address = addr_r;
  assign out_byte_value   = word_r[7:0];
  assign out_last_byte    = last;

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    four_nxt  = four_r;
    if (s2_ready) begin
      valid_nxt = s2_valid;
      addr_nxt  = s2_data.addr;
      word_nxt  = s2_data.word;
      four_nxt  = s2_data.four_bytes;
      cnt_nxt   = 2'd0;
    end else if (out_ready) begin
      addr_nxt = (addr_r + 48'd1) & ADDR_MASK;
      word_nxt = {8'b0, word_r[31:8]};
      cnt_nxt  = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    addr_r <= addr_nxt;
    word_r <= word_nxt;
    four_r <= four_nxt;
  end

endmodule

// ----- sv/framebuffer_pixel_writer_unit.sv -----
// Top level of the framebuffer pixel writer: registers, pipeline and checks.
//
// The input channel (in_valid/in_ready) takes one pixel request: a column,
// a row and 8-bit red, green and blue levels. A request whose coordinate
// falls outside the configured frame is consumed and produces nothing.
// Every other request produces 3 or 4 byte writes on the output channel
// (out_valid/out_ready), low byte first, at consecutive addresses starting
// at base + row * pitch + column * bytes; the final byte has out_last_byte.
// The configuration port writes one register per cycle with
// cfg_write_enable; it must only be used while the pipeline is empty.
// Pipeline: the front stage registers the frame check and multiplies, the
// pack stage then registers the address sum and packing, and the byte
// output register in the serializer stage follows them.
// Throughput: one request per cycle can enter the pipeline while in_ready
// is high, but the single byte output port sets the sustained rate, as
// each pixel takes 3 or 4 byte writes on it, depending on pixel_bytes.
// When the receiver stalls, the byte register holds and the two earlier
// stages fill up before in_ready drops; nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and loads the default
// configuration (640 by 480 frame, 2560-byte pitch, 4 bytes per pixel).
module framebuffer_pixel_writer_unit import fpw_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = 8192,
  parameter int unsigned ADDRESS_BITS  = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_pixel_x,
  input  logic [12:0] in_pixel_y,
  input  logic [7:0]  in_red_level,
  input  logic [7:0]  in_green_level,
  input  logic [7:0]  in_blue_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_byte_address,
  output logic [7:0]  out_byte_value,
  output logic        out_last_byte
);

  localparam int unsigned AW_EFF = (ADDRESS_BITS < FIELD_ADDR_W) ? ADDRESS_BITS
                                                                 : FIELD_ADDR_W;
  localparam logic [47:0] ADDR_MASK = {48{1'b1}} >> (FIELD_ADDR_W - AW_EFF);

  cfg_t   cfg_r, cfg_nxt;
  logic   s1_valid, s1_ready;
  front_t s1_data;
  logic   s2_valid, s2_ready;
  pix_t   s2_data;

  // Register writes. The index covers exactly the eight registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_enable) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_ADDRESS: cfg_nxt.base_address = cfg_data;
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_data[13:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[13:0];
        REG_LINE_PITCH:   cfg_nxt.line_pitch   = cfg_data[15:0];
        REG_PIXEL_BYTES:  cfg_nxt.pixel_bytes  = cfg_data[2:0];
        REG_RED_LAYOUT:   cfg_nxt.red_layout   = cfg_data[8:0];
        REG_GREEN_LAYOUT: cfg_nxt.green_layout = cfg_data[8:0];
        REG_BLUE_LAYOUT:  cfg_nxt.blue_layout  = cfg_data[8:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= 48'd0;
      cfg_r.frame_width  <= 14'd640;
      cfg_r.frame_height <= 14'd480;
      cfg_r.line_pitch   <= 16'd2560;
      cfg_r.pixel_bytes  <= 3'd4;
      cfg_r.red_layout   <= 9'd272;
      cfg_r.green_layout <= 9'd264;
      cfg_r.blue_layout  <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Frame check and the row, column and channel products.
  fpw_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_red_level  (in_red_level),
    .in_green_level(in_green_level),
    .in_blue_level (in_blue_level),
    .s1_valid      (s1_valid),
    .s1_ready      (s1_ready),
    .s1_data       (s1_data)
  );

  // Address sum and rounded channel packing into the 32-bit word.
  fpw_pack #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .s1_valid(s1_valid),
    .s1_ready(s1_ready),
    .s1_data (s1_data),
    .s2_valid(s2_valid),
    .s2_ready(s2_ready),
    .s2_data (s2_data)
  );

  // Byte output register, one byte write per cycle while out_ready is high.
  fpw_ser #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .s2_valid        (s2_valid),
    .s2_ready        (s2_ready),
    .s2_data         (s2_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_address(out_byte_address),
    .out_byte_value  (out_byte_value),
    .out_last_byte   (out_last_byte)
  );

`ifndef ASSERT_OFF
  // Back-pressure on the input only ever comes from a waiting output byte.
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while no byte is pending");

  // The bytes of one pixel follow each other without a gap.
  a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=> out_valid)
    else $error("pixel byte sequence broken");

  // Consecutive bytes of one pixel go to consecutive addresses.
  a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=>
      out_byte_address == (($past(out_byte_address) + 48'd1) & ADDR_MASK))
    else $error("byte address did not advance by one");
`endif

endmodule
